[rtl/core/bbfq_pkg.sv]
package bbfq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int HANDLE_BITS = 16;
    localparam int BYTES_W     = 24;
    localparam int TOTAL_W     = 29;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 1;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = COUNT_W + 1;
    // running total needs one bit more than the budget while a push is being trimmed
    localparam int WORK_W  = TOTAL_W + 1;

    localparam logic [TOTAL_W-1:0] BUDGET_RESET = TOTAL_W'(1048576);

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_EVICTED  = 3'd2,
        KIND_POPPED   = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_BUDGET      = 1'b0,
        CFG_REJECT_WHEN_FULL = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TRIM,
        ST_EVICT
    } state_t;

endpackage

[rtl/core/bbfq_req_if.sv]
interface bbfq_req_if;
    import bbfq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [HANDLE_BITS-1:0] frame_handle;
    logic [BYTES_W-1:0]     frame_bytes;

    modport source (output valid, output operation, output frame_handle,
                    output frame_bytes, input ready);
    modport sink   (input valid, input operation, input frame_handle,
                    input frame_bytes, output ready);
endinterface

[rtl/core/bbfq_rsp_if.sv]
interface bbfq_rsp_if;
    import bbfq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [BYTES_W-1:0]     out_bytes;
    logic [TOTAL_W-1:0]     queued_bytes;
    logic                   full_seen;
    logic                   last;

    modport source (output valid, output kind, output out_handle, output out_bytes,
                    output queued_bytes, output full_seen, output last, input ready);
    modport sink   (input valid, input kind, input out_handle, input out_bytes,
                    input queued_bytes, input full_seen, input last, output ready);
endinterface

[rtl/core/byte_budget_frame_queue_top.sv]
// an item is taken in the idle state and held; a pop, a refused push or a push that fits
//   gets a beat worked out in the execute state and registered once the output is free
// one item at a time; each frame dropped for the budget adds a check state, then an evict
//   state on the head read of the single store read port; a drop-mode push that meets a
//   full store or the budget and keeps its frame ends in a final check state
// reset: pointers, count, total and sticky flag clear, budget 1048576, drop mode, store kept
module byte_budget_frame_queue_top (
    input  logic                          clk,
    input  logic                          rst_n,
    bbfq_req_if.sink                      req,
    bbfq_rsp_if.source                    rsp,
    input  logic                          cfg_wr_en,
    input  logic [bbfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbfq_pkg::TOTAL_W-1:0]  cfg_wr_data
);
    import bbfq_pkg::*;

    // control state
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [WORK_W-1:0]    total_reg, total_next;
    logic                 flag_reg, flag_next;
    logic [TOTAL_W-1:0]   budget_reg;
    logic                 mode_reg;

    // item held while it is worked on
    logic                   op_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [BYTES_W-1:0]     bytes_reg;

    // output register, parts the result side from the work
    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [BYTES_W-1:0]     out_bytes_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic                   out_full_reg;
    logic                   out_last_reg;

    // entry store, read port always addressed by the head
    logic [HANDLE_BITS-1:0] handle_mem [QUEUE_DEPTH];
    logic [BYTES_W-1:0]     size_mem   [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] rd_handle_q;
    logic [BYTES_W-1:0]     rd_bytes_q;

    logic                   wr_en;
    logic [ADDR_W-1:0]      tail_addr;
    logic [SUM_W-1:0]       tail_sum;

    logic                   req_beat;
    logic                   out_free;
    logic                   emit;
    kind_t                  emit_kind;
    logic [HANDLE_BITS-1:0] emit_handle;
    logic [BYTES_W-1:0]     emit_bytes;
    logic [TOTAL_W-1:0]     emit_total;
    logic                   emit_last;

    logic [WORK_W-1:0]      push_total;
    logic [WORK_W-1:0]      budget_ext;
    logic [WORK_W-1:0]      head_bytes_ext;
    logic [WORK_W-1:0]      total_less_head;
    logic [ADDR_W-1:0]      head_inc;
    logic                   store_full;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // tail slot wraps for any depth, power of two or not
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_addr = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? ADDR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                     : ADDR_W'(tail_sum);
    assign head_inc  = (head_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign store_full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign push_total      = total_reg + WORK_W'(bytes_reg);
    assign budget_ext      = WORK_W'(budget_reg);
    assign head_bytes_ext  = WORK_W'(rd_bytes_q);
    // removing the front frame, clamped at zero
    assign total_less_head = (total_reg >= head_bytes_ext) ? total_reg - head_bytes_ext : '0;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        flag_next   = flag_reg;
        wr_en       = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_ACCEPTED;
        emit_handle = hnd_reg;
        emit_bytes  = bytes_reg;
        emit_last   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                if (op_reg == OP_POP)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                        if (count_reg == '0)
                        begin
                            emit_kind   = KIND_EMPTY;
                            emit_handle = '0;
                            emit_bytes  = '0;
                        end
                        else
                        begin
                            emit_kind   = KIND_POPPED;
                            emit_handle = rd_handle_q;
                            emit_bytes  = rd_bytes_q;
                            head_next   = head_inc;
                            count_next  = count_reg - 1'b1;
                            total_next  = total_less_head;
                        end
                    end
                end
                else if (mode_reg)
                begin
                    // reject mode: refuse on a full store or a blown budget
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                        if (store_full || (push_total > budget_ext))
                        begin
                            flag_next = 1'b1;
                            emit_kind = KIND_REJECTED;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = push_total;
                            emit_kind  = KIND_ACCEPTED;
                        end
                    end
                end
                else if (store_full)
                begin
                    // drop mode, store full: evict the head and reuse its slot
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_kind   = KIND_EVICTED;
                        emit_handle = rd_handle_q;
                        emit_bytes  = rd_bytes_q;
                        wr_en       = 1'b1;
                        head_next   = head_inc;
                        total_next  = total_less_head + WORK_W'(bytes_reg);
                        state_next  = ST_TRIM;
                    end
                end
                else if (push_total <= budget_ext)
                begin
                    // fits at once, no trimming
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_kind  = KIND_ACCEPTED;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        total_next = push_total;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    total_next = push_total;
                    state_next = ST_TRIM;
                end
            end

            ST_TRIM:
            begin
                // head read is issued here, data is used in the evict cycle
                if (total_reg > budget_ext)
                    state_next = ST_EVICT;
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_kind  = KIND_ACCEPTED;
                    state_next = ST_IDLE;
                end
            end

            ST_EVICT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_EVICTED;
                    emit_handle = rd_handle_q;
                    emit_bytes  = rd_bytes_q;
                    head_next   = head_inc;
                    count_next  = count_reg - 1'b1;
                    total_next  = total_less_head;
                    // the new frame itself went out last
                    if (count_reg == COUNT_W'(1))
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_TRIM;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a frame dropped to make room reports the total before the new frame joins
        emit_total = (state_reg == ST_EXEC && op_reg == OP_PUSH && !mode_reg && store_full)
                   ? total_less_head[TOTAL_W-1:0] : total_next[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
            flag_reg  <= flag_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            mode_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BYTE_BUDGET:      budget_reg <= cfg_wr_data;
                CFG_REJECT_WHEN_FULL: mode_reg   <= cfg_wr_data[0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            op_reg    <= req.operation;
            hnd_reg   <= req.frame_handle;
            bytes_reg <= req.frame_bytes;
        end
        if (emit)
        begin
            out_kind_reg   <= emit_kind;
            out_handle_reg <= emit_handle;
            out_bytes_reg  <= emit_bytes;
            out_total_reg  <= emit_total;
            out_full_reg   <= flag_next;
            out_last_reg   <= emit_last;
        end
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_mem[tail_addr] <= hnd_reg;
            size_mem[tail_addr]   <= bytes_reg;
        end
        rd_handle_q <= handle_mem[head_reg];
        rd_bytes_q  <= size_mem[head_reg];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.out_handle   = out_handle_reg;
    assign rsp.out_bytes    = out_bytes_reg;
    assign rsp.queued_bytes = out_total_reg;
    assign rsp.full_seen    = out_full_reg;
    assign rsp.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("entry count above store depth");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("bytes held with no entries");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |=> flag_reg)
        else $error("rejected flag cleared");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !req.ready)
        else $error("second item taken while one is in work");

    a_idle_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (total_reg <= WORK_W'({TOTAL_W{1'b1}})))
        else $error("held total beyond field range between items");
`endif

endmodule

[tb/sv/bbfq_checker.sv]
`timescale 1ns / 100ps

module bbfq_checker
    import bbfq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bbfq_req_if                  req,
    bbfq_rsp_if                  rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOTAL_W-1:0]   cfg_wr_data,
    output int                   mismatch_count,
    output int                   beats_due
);

    // well above the beats one item can leave in flight
    localparam int DUE_DEPTH = 64;

    typedef struct packed {
        kind_t                  kind;
        logic [HANDLE_BITS-1:0] handle;
        logic [BYTES_W-1:0]     bytes;
        logic [TOTAL_W-1:0]     queued;
        logic                   full_seen;
        logic                   last;
    } result_beat_t;

    // shadow of the frame queue
    logic [HANDLE_BITS-1:0] handle_mem [QUEUE_DEPTH];
    logic [BYTES_W-1:0]     size_mem   [QUEUE_DEPTH];
    logic [ADDR_W-1:0]      head;
    logic [COUNT_W-1:0]     count;
    logic [WORK_W-1:0]      held_bytes;
    logic                   sticky_reject;
    logic [TOTAL_W-1:0]     budget;
    logic                   reject_mode;

    // expected beats, in order
    result_beat_t due_beats [DUE_DEPTH];
    int           due_wr;
    int           due_rd;

    task automatic note_beat(kind_t k, logic [HANDLE_BITS-1:0] h, logic [BYTES_W-1:0] b);
        result_beat_t e;
        e.kind      = k;
        e.handle    = h;
        e.bytes     = b;
        e.queued    = held_bytes[TOTAL_W-1:0];
        e.full_seen = sticky_reject;
        e.last      = 1'b0;
        due_beats[due_wr % DUE_DEPTH] = e;
        due_wr++;
    endtask

    task automatic take_oldest(output logic [HANDLE_BITS-1:0] h, output logic [BYTES_W-1:0] b);
        h = handle_mem[head];
        b = size_mem[head];
        head = (int'(head) == QUEUE_DEPTH - 1) ? '0 : head + 1'b1;
        count = count - 1'b1;
        held_bytes = (held_bytes >= b) ? held_bytes - b : '0;
    endtask

    task automatic append_frame(logic [HANDLE_BITS-1:0] h, logic [BYTES_W-1:0] b);
        int slot;
        slot = (int'(head) + int'(count)) % QUEUE_DEPTH;
        handle_mem[slot] = h;
        size_mem[slot]   = b;
        count = count + 1'b1;
        held_bytes = held_bytes + b;
    endtask

    task automatic predict_frame_op(op_t op, logic [HANDLE_BITS-1:0] h, logic [BYTES_W-1:0] b);
        logic [HANDLE_BITS-1:0] gone_h;
        logic [BYTES_W-1:0]     gone_b;
        logic                   kept;
        kept = 1'b1;
        if (op == OP_POP)
        begin
            if (count == 0)
                note_beat(KIND_EMPTY, '0, '0);
            else
            begin
                take_oldest(gone_h, gone_b);
                note_beat(KIND_POPPED, gone_h, gone_b);
            end
        end
        else if (reject_mode)
        begin
            if (count >= QUEUE_DEPTH || held_bytes + b > budget)
            begin
                sticky_reject = 1'b1;
                note_beat(KIND_REJECTED, h, b);
            end
            else
            begin
                append_frame(h, b);
                note_beat(KIND_ACCEPTED, h, b);
            end
        end
        else
        begin
            if (count >= QUEUE_DEPTH)
            begin
                take_oldest(gone_h, gone_b);
                note_beat(KIND_EVICTED, gone_h, gone_b);
            end
            append_frame(h, b);
            while (held_bytes > budget && count > 0)
            begin
                // the new frame itself goes when it is the only one left
                if (count == 1)
                    kept = 1'b0;
                take_oldest(gone_h, gone_b);
                note_beat(KIND_EVICTED, gone_h, gone_b);
            end
            if (kept)
                note_beat(KIND_ACCEPTED, h, b);
        end
        due_beats[(due_wr - 1) % DUE_DEPTH].last = 1'b1;
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic compare_beat();
        result_beat_t want;
        if (due_wr == due_rd)
        begin
            mismatch_count++;
            $display("%0t: beat expected none, actual kind %0h handle %0h bytes %0h",
                     $time, rsp.kind, rsp.out_handle, rsp.out_bytes);
        end
        else
        begin
            want = due_beats[due_rd % DUE_DEPTH];
            due_rd++;
            check_field("kind", 32'(want.kind), 32'(rsp.kind));
            check_field("out_handle", 32'(want.handle), 32'(rsp.out_handle));
            check_field("out_bytes", 32'(want.bytes), 32'(rsp.out_bytes));
            check_field("queued_bytes", 32'(want.queued), 32'(rsp.queued_bytes));
            check_field("full_seen", 32'(want.full_seen), 32'(rsp.full_seen));
            check_field("last", 32'(want.last), 32'(rsp.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head           = '0;
            count          = '0;
            held_bytes     = '0;
            sticky_reject  = 1'b0;
            budget         = BUDGET_RESET;
            reject_mode    = 1'b0;
            mismatch_count = 0;
            beats_due      = 0;
            due_wr         = 0;
            due_rd         = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                compare_beat();
            if (cfg_wr_en === 1'b1)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_BYTE_BUDGET:      budget = cfg_wr_data;
                    CFG_REJECT_WHEN_FULL: reject_mode = cfg_wr_data[0];
                    default:              ;
                endcase
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_frame_op(op_t'(req.operation), req.frame_handle, req.frame_bytes);
            beats_due = due_wr - due_rd;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import bbfq_pkg::*;

    localparam int                 HALF_PERIOD   = 6;
    localparam int                 RESET_CYCLES  = 7;
    localparam int                 HOLD_CYCLES   = 300;
    localparam int                 SETTLE_CYCLES = 4;
    localparam int                 TAIL_CYCLES   = 40;
    localparam int                 IDLE_PCT      = 28;
    localparam int unsigned        MAX_FRAME     = (1 << BYTES_W) - 1;
    localparam logic [TOTAL_W-1:0] BUDGET_MAX    = '1;

    logic clk;
    logic rst_n;

    bbfq_req_if req_ch ();
    bbfq_rsp_if rsp_ch ();

    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TOTAL_W-1:0]   cfg_wr_data;

    int fail_count;
    int beats_due;

    // the stimulus bumps this to ask the receiver for one long hold-off
    int hold_asked = 0;
    // no idling on either side while set
    bit steady_run = 1'b0;

    byte_budget_frame_queue_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // watches both channels and the register port, predicts and compares
    bbfq_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (fail_count),
        .beats_due      (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // generous cap on the whole run
    initial
    begin : watchdog
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here
    initial
    begin : receiver
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != holds_done)
            begin
                holds_done = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (steady_run)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one beat at the falling edge and hold it until the block takes it
    task automatic send_frame(op_t op, logic [HANDLE_BITS-1:0] h, logic [BYTES_W-1:0] b);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.frame_handle <= h;
        req_ch.frame_bytes  <= b;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        // sometimes leave a gap before the next beat
        if (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (beats_due == 0);
        // let the block settle back to idle
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [TOTAL_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // registers change only with the block drained
    task automatic set_policy(logic [TOTAL_W-1:0] new_budget, logic reject);
        wait_drained();
        write_reg(CFG_BYTE_BUDGET, new_budget);
        write_reg(CFG_REJECT_WHEN_FULL, TOTAL_W'(reject));
    endtask

    // sizes mostly scaled to the budget, with zero, all-ones and full-range ones mixed in
    task automatic random_frame(int pop_pct, int unsigned size_cap);
        op_t                op;
        logic [BYTES_W-1:0] frame_size;
        int unsigned        pick;
        op   = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
        pick = $urandom_range(99);
        if (pick < 8)
            frame_size = '0;
        else if (pick < 14)
            frame_size = '1;
        else if (pick < 30)
            frame_size = BYTES_W'($urandom);
        else
            frame_size = BYTES_W'($urandom_range(size_cap));
        send_frame(op, HANDLE_BITS'($urandom), frame_size);
    endtask

    task automatic random_run(int items, int pop_pct, logic [TOTAL_W-1:0] cur_budget);
        int unsigned size_cap;
        size_cap = cur_budget / 6;
        if (size_cap > MAX_FRAME)
            size_cap = MAX_FRAME;
        if (size_cap == 0)
            size_cap = 1;
        repeat (items) random_frame(pop_pct, size_cap);
    endtask

    initial
    begin : stimulus
        logic [TOTAL_W-1:0] mid_budget;

        // every input known from time zero
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_PUSH;
        req_ch.frame_handle = '0;
        req_ch.frame_bytes  = '0;
        cfg_wr_en           = 1'b0;
        cfg_index           = CFG_BYTE_BUDGET;
        cfg_wr_data         = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed: reset policy, 1 MiB budget, drop oldest ----
        // pop with nothing queued
        send_frame(OP_POP, 16'h0000, 24'd0);
        // zero-size frame with all handle bits set
        send_frame(OP_PUSH, 16'hFFFF, 24'd0);
        // largest frame alone overflows: the queued frame goes, then the new one itself
        send_frame(OP_PUSH, 16'h0000, 24'hFFFFFF);
        // third frame pushes the total over, oldest is dropped
        send_frame(OP_PUSH, 16'h0001, 24'd400000);
        send_frame(OP_PUSH, 16'h0002, 24'd400000);
        send_frame(OP_PUSH, 16'h0003, 24'd400000);
        send_frame(OP_POP, 16'h0000, 24'd0);
        send_frame(OP_POP, 16'h0000, 24'd0);
        send_frame(OP_POP, 16'h0000, 24'd0);

        // ---- directed: refuse mode, tight budget ----
        set_policy(TOTAL_W'(1000), 1'b1);
        send_frame(OP_PUSH, 16'h00AA, 24'd600);
        // over budget: refused, sticky flag sets
        send_frame(OP_PUSH, 16'h0055, 24'd600);
        // lands exactly on the budget
        send_frame(OP_PUSH, 16'h1234, 24'd400);
        // zero size still fits a full budget
        send_frame(OP_PUSH, 16'h4321, 24'd0);
        send_frame(OP_PUSH, 16'h1111, 24'd1);

        // budget dropped below what is held: refused until pops make room
        set_policy(TOTAL_W'(500), 1'b1);
        send_frame(OP_PUSH, 16'h2222, 24'd0);
        send_frame(OP_POP, 16'h0000, 24'd0);
        send_frame(OP_PUSH, 16'h3333, 24'd100);

        // back to drop mode below the held total: next push trims the queue
        set_policy(TOTAL_W'(300), 1'b0);
        send_frame(OP_PUSH, 16'h5555, 24'd0);

        // ---- random phases ----
        // huge budget, few pops: the store fills and full-store eviction runs
        set_policy(BUDGET_MAX, 1'b0);
        random_run(60, 10, BUDGET_MAX);

        // store full of one-byte frames, then a zero budget: one push
        // drops the oldest for room and then trims everything including itself
        repeat (QUEUE_DEPTH) send_frame(OP_PUSH, HANDLE_BITS'($urandom), BYTES_W'(1));
        set_policy('0, 1'b0);
        send_frame(OP_PUSH, HANDLE_BITS'($urandom), BYTES_W'(1));
        random_run(20, 30, '0);

        // small budget in refuse mode
        set_policy(TOTAL_W'(4096), 1'b1);
        random_run(60, 40, TOTAL_W'(4096));

        // huge budget in refuse mode: refusals come from the full store
        set_policy(BUDGET_MAX, 1'b1);
        random_run(50, 5, BUDGET_MAX);

        // reset budget, drop mode; the receiver holds off while the sender keeps offering
        set_policy(BUDGET_RESET, 1'b0);
        hold_asked++;
        random_run(60, 30, BUDGET_RESET);

        // random budget in refuse mode, with a full drain in the middle
        mid_budget = TOTAL_W'($urandom);
        set_policy(mid_budget, 1'b1);
        random_run(30, 30, mid_budget);
        wait_drained();
        random_run(30, 30, mid_budget);

        // modest random budget, drop mode, no idling anywhere
        mid_budget = TOTAL_W'($urandom_range(200000, 1));
        set_policy(mid_budget, 1'b0);
        steady_run = 1'b1;
        random_run(60, 25, mid_budget);
        steady_run = 1'b0;

        // everything back, then a quiet tail to catch stray beats
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
